// ===== design/ludp_pkg.sv =====
// ----------------------------------------------------------------------------
// ludp_pkg: shared types and constants of the pivoted LU factorization block
// Fixed field widths, saturation limits and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ludp_pkg;

   localparam int VALUE_W   = 32;   // Q16.16 element width
   localparam int FRAC_W    = 16;   // fraction bits
   localparam int IDX_W     = 3;    // row / column field width
   localparam int SIZE_W    = 4;    // matrix_size register width
   localparam int CNT_W     = 7;    // element load counter
   localparam int QUO_W     = VALUE_W + FRAC_W;  // divider quotient width
   localparam int DCNT_W    = 6;    // divider step counter

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic [QUO_W-1:0] QUO_POS_LIM = 48'h0000_7FFF_FFFF;
   localparam logic [QUO_W-1:0] QUO_NEG_LIM = 48'h0000_8000_0000;
   localparam logic [DCNT_W-1:0] DIV_LAST   = 6'(QUO_W - 1);
   localparam logic signed [63:0] TRUNC_ADJ = 64'sd65535;

   // Sequencer states, one-hot
   typedef enum logic [17:0] {
      S_LOAD  = 18'b00_0000_0000_0000_0001,
      S_COL   = 18'b00_0000_0000_0000_0010,
      S_SRD   = 18'b00_0000_0000_0000_0100,
      S_SCHK  = 18'b00_0000_0000_0000_1000,
      S_PRD   = 18'b00_0000_0000_0001_0000,
      S_PCAP  = 18'b00_0000_0000_0010_0000,
      S_ERD   = 18'b00_0000_0000_0100_0000,
      S_DIVS  = 18'b00_0000_0000_1000_0000,
      S_DIV   = 18'b00_0000_0001_0000_0000,
      S_MSAT  = 18'b00_0000_0010_0000_0000,
      S_URD   = 18'b00_0000_0100_0000_0000,
      S_UMUL  = 18'b00_0000_1000_0000_0000,
      S_USHF  = 18'b00_0001_0000_0000_0000,
      S_UWR   = 18'b00_0010_0000_0000_0000,
      S_MWR   = 18'b00_0100_0000_0000_0000,
      S_ORD   = 18'b00_1000_0000_0000_0000,
      S_OCAP  = 18'b01_0000_0000_0000_0000,
      S_OWAIT = 18'b10_0000_0000_0000_0000
   } state_type;

endpackage

// ===== design/ludp_if.sv =====
// ----------------------------------------------------------------------------
// ludp_if: channel interfaces of the pivoted LU factorization block
// Element input, result output and size register write channels.
// ----------------------------------------------------------------------------
interface ludp_req_if import ludp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] element_value;
   logic                      last_element;
   modport source (output valid, element_value, last_element, input ready);
   modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface ludp_rsp_if import ludp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] lu_value;
   logic [IDX_W-1:0]          out_row;
   logic [IDX_W-1:0]          out_col;
   logic [IDX_W-1:0]          perm_row;
   logic                      factor_failed;
   logic                      last_result;
   modport source (output valid, lu_value, out_row, out_col, perm_row, factor_failed,
                   last_result, input ready);
   modport sink   (input valid, lu_value, out_row, out_col, perm_row, factor_failed,
                   last_result, output ready);
endinterface

interface ludp_csr_if import ludp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] matrix_size;
   modport source (output valid, matrix_size, input ready);
   modport sink   (input valid, matrix_size, output ready);
endinterface

// ===== design/ludp_ram.sv =====
// ----------------------------------------------------------------------------
// ludp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ludp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lu_decomposition_pivoted_top.sv =====
// ----------------------------------------------------------------------------
// lu_decomposition_pivoted_top: LU factorization with first-nonzero pivoting
// Loads a Q16.16 matrix, factorizes it in place, streams out packed LU.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_ch sets the order N (0 acts as 1, above MAX_N as MAX_N); always ready.
//  - req_ch takes one element per cycle, row-major. Elements past N*N are
//    dropped. The item with last_element set starts the factorization; the
//    channel then stays not ready until the final result is taken.
//  - Pivot column i checks the column bound, then searches rows from i down
//    for the first nonzero entry and fetches the pivot row into registers;
//    each eliminated row runs the serial divider (setup, then one quotient
//    bit per cycle over 48 bits), updates each column through the shared
//    multiplier and subtractor, and writes the multiplier.
//  - rsp_ch then gives N*N results, row by row, each by RAM read, output
//    register and handshake; the next read waits until the result is taken.
//  - A stalled receiver holds the output register; nothing else advances.
//  - After the final result the store, permutation and fail flag are cleared
//    at once (per-entry valid bits) and loading resumes the next cycle.
//  - Reset clears the same state and sets N to 8.
// ----------------------------------------------------------------------------
module lu_decomposition_pivoted_top import ludp_pkg::*; #(
   parameter int MAX_N = 8
) (
   input  logic      clock,
   input  logic      reset,
   ludp_req_if.sink   req_ch,
   ludp_rsp_if.source rsp_ch,
   ludp_csr_if.sink   csr_ch
);

   localparam int DEPTH = MAX_N * MAX_N;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_N);
   localparam logic [SIZE_W-1:0] N_MAX = SIZE_W'(MAX_N);

   // Packed element address of a physical row and column
   function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                               input logic [IDX_W-1:0] col);
      return AW'(int'(row) * MAX_N + int'(col));
   endfunction

   // Row and column of a load count for order n (count < n*n)
   function automatic logic [2*IDX_W-1:0] load_pos(input logic [CNT_W-1:0] cnt,
                                                  input logic [SIZE_W-1:0] n);
      logic [CNT_W-1:0] rem;
      logic [IDX_W-1:0] quo;
      rem = cnt;
      quo = '0;
      for (int b = IDX_W - 1; b >= 0; b--) begin
         if (rem >= (CNT_W'(n) << b)) begin
            rem    = rem - (CNT_W'(n) << b);
            quo[b] = 1'b1;
         end
      end
      return {quo, rem[IDX_W-1:0]};
   endfunction

   // Control registers
   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  msize_ff, msize_in;
   logic [CNT_W-1:0]   lcnt_ff, lcnt_in;
   logic               fail_ff, fail_in;
   logic [IDX_W-1:0]   perm_ff [MAX_N];
   logic [IDX_W-1:0]   perm_in [MAX_N];
   logic [DEPTH-1:0]   vbit_ff, vbit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Loop counters, wide enough to hold N
   logic [SIZE_W-1:0]  i_ff, i_in, k_ff, k_in, j_ff, j_in, c_ff, c_in, r_ff, r_in;

   // Datapath registers
   logic signed [VALUE_W-1:0] prow_ff [MAX_N];
   logic signed [VALUE_W-1:0] prow_in [MAX_N];
   logic signed [VALUE_W-1:0] m_ff, m_in, x_ff, x_in, p_ff, p_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic [QUO_W-1:0]          dvd_ff, dvd_in;
   logic [VALUE_W:0]          rem_ff, rem_in;
   logic [VALUE_W-1:0]        dsor_ff, dsor_in;
   logic                      neg_ff, neg_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic                      rvld_ff;

   // Output registers
   logic signed [VALUE_W-1:0] o_val_ff, o_val_in;
   logic [IDX_W-1:0]          o_row_ff, o_row_in, o_col_ff, o_col_in, o_perm_ff, o_perm_in;
   logic                      o_fail_ff, o_fail_in, o_last_ff, o_last_in;

   // RAM port signals
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic signed [VALUE_W-1:0] ram_wdata, ram_rdata, rd_val;

   // Helpers
   logic [SIZE_W-1:0]         n_eff;
   logic [2*SIZE_W-1:0]       nn;
   logic [2*IDX_W-1:0]        lpos;
   logic [IDX_W-1:0]          prow_phys, erow_phys, srow_phys, orow_phys;
   logic                      req_fire, out_last;
   logic [VALUE_W:0]          trial;
   logic                      ge;
   logic signed [63:0]        adj, shv;
   logic signed [VALUE_W:0]   diff;
   logic signed [VALUE_W-1:0] piv, diff_sat;
   logic [VALUE_W-1:0]        a_mag;

   ludp_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Effective order
   always_comb begin
      if (msize_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (msize_ff > N_MAX) begin
         n_eff = N_MAX;
      end else begin
         n_eff = msize_ff;
      end
   end

   assign nn        = (2*SIZE_W)'(n_eff) * (2*SIZE_W)'(n_eff);
   assign lpos      = load_pos(lcnt_ff, n_eff);
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rd_val    = rvld_ff ? ram_rdata : '0;
   assign srow_phys = perm_ff[k_ff[PW-1:0]];
   assign prow_phys = perm_ff[i_ff[PW-1:0]];
   assign erow_phys = perm_ff[j_ff[PW-1:0]];
   assign orow_phys = perm_ff[r_ff[PW-1:0]];
   assign out_last  = ((r_ff + 1'b1) == n_eff) && ((c_ff + 1'b1) == n_eff);
   assign piv       = prow_ff[i_ff[PW-1:0]];

   // Divider step: one quotient bit per cycle
   assign trial = {rem_ff[VALUE_W-1:0], dvd_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, dsor_ff};

   // Product scaling (truncate toward zero) and saturated difference
   assign adj  = prod_ff[63] ? prod_ff + TRUNC_ADJ : prod_ff;
   assign shv  = adj >>> FRAC_W;
   assign diff = {x_ff[VALUE_W-1], x_ff} - {p_ff[VALUE_W-1], p_ff};
   always_comb begin
      if (diff > (VALUE_W+1)'(VAL_MAX)) begin
         diff_sat = VAL_MAX;
      end else if (diff < (VALUE_W+1)'(VAL_MIN)) begin
         diff_sat = VAL_MIN;
      end else begin
         diff_sat = diff[VALUE_W-1:0];
      end
   end

   assign a_mag = rd_val[VALUE_W-1] ? VALUE_W'(-rd_val) : VALUE_W'(rd_val);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      msize_in     = msize_ff;
      lcnt_in      = lcnt_ff;
      fail_in      = fail_ff;
      perm_in      = perm_ff;
      vbit_in      = vbit_ff;
      rsp_valid_in = rsp_valid_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      prow_in      = prow_ff;
      m_in         = m_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dsor_in      = dsor_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      o_val_in     = o_val_ff;
      o_row_in     = o_row_ff;
      o_col_in     = o_col_ff;
      o_perm_in    = o_perm_ff;
      o_fail_in    = o_fail_ff;
      o_last_in    = o_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      if (csr_ch.valid) begin
         msize_in = csr_ch.matrix_size;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if ((2*SIZE_W)'(lcnt_ff) < nn) begin
                  ram_we    = 1'b1;
                  ram_waddr = cell_addr(lpos[2*IDX_W-1:IDX_W], lpos[IDX_W-1:0]);
                  ram_wdata = req_ch.element_value;
                  vbit_in[ram_waddr] = 1'b1;
                  lcnt_in   = lcnt_ff + 1'b1;
               end
               if (req_ch.last_element) begin
                  i_in     = '0;
                  state_in = S_COL;
               end
            end
         end
         S_COL: begin
            if ((i_ff + 1'b1) >= n_eff) begin
               r_in     = '0;
               c_in     = '0;
               state_in = S_ORD;
            end else begin
               k_in     = i_ff;
               state_in = S_SRD;
            end
         end
         // Pivot search down column i
         S_SRD: begin
            ram_raddr = cell_addr(srow_phys, i_ff[IDX_W-1:0]);
            state_in  = S_SCHK;
         end
         S_SCHK: begin
            if (rd_val != '0) begin
               perm_in[k_ff[PW-1:0]] = perm_ff[i_ff[PW-1:0]];
               perm_in[i_ff[PW-1:0]] = perm_ff[k_ff[PW-1:0]];
               c_in     = i_ff;
               state_in = S_PRD;
            end else if ((k_ff + 1'b1) == n_eff) begin
               fail_in  = 1'b1;
               r_in     = '0;
               c_in     = '0;
               state_in = S_ORD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         // Fetch pivot row into registers
         S_PRD: begin
            ram_raddr = cell_addr(prow_phys, c_ff[IDX_W-1:0]);
            state_in  = S_PCAP;
         end
         S_PCAP: begin
            prow_in[c_ff[PW-1:0]] = rd_val;
            if ((c_ff + 1'b1) == n_eff) begin
               j_in     = i_ff + 1'b1;
               state_in = S_ERD;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         // Multiplier for row j
         S_ERD: begin
            ram_raddr = cell_addr(erow_phys, i_ff[IDX_W-1:0]);
            state_in  = S_DIVS;
         end
         S_DIVS: begin
            dvd_in   = {a_mag, {FRAC_W{1'b0}}};
            rem_in   = '0;
            dsor_in  = piv[VALUE_W-1] ? VALUE_W'(-piv) : VALUE_W'(piv);
            neg_in   = rd_val[VALUE_W-1] ^ piv[VALUE_W-1];
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = ge ? trial - {1'b0, dsor_ff} : trial;
            dvd_in  = {dvd_ff[QUO_W-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_LAST) begin
               state_in = S_MSAT;
            end
         end
         S_MSAT: begin
            if (neg_ff) begin
               m_in = (dvd_ff > QUO_NEG_LIM) ? VAL_MIN : VALUE_W'(-dvd_ff);
            end else begin
               m_in = (dvd_ff > QUO_POS_LIM) ? VAL_MAX : VALUE_W'(dvd_ff);
            end
            c_in     = i_ff + 1'b1;
            state_in = S_URD;
         end
         // Row update through the shared multiplier
         S_URD: begin
            ram_raddr = cell_addr(erow_phys, c_ff[IDX_W-1:0]);
            state_in  = S_UMUL;
         end
         S_UMUL: begin
            x_in     = rd_val;
            prod_in  = m_ff * prow_ff[c_ff[PW-1:0]];
            state_in = S_USHF;
         end
         S_USHF: begin
            if (shv > 64'(VAL_MAX)) begin
               p_in = VAL_MAX;
            end else if (shv < 64'(VAL_MIN)) begin
               p_in = VAL_MIN;
            end else begin
               p_in = shv[VALUE_W-1:0];
            end
            state_in = S_UWR;
         end
         S_UWR: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(erow_phys, c_ff[IDX_W-1:0]);
            ram_wdata = diff_sat;
            vbit_in[ram_waddr] = 1'b1;
            if ((c_ff + 1'b1) == n_eff) begin
               state_in = S_MWR;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_URD;
            end
         end
         S_MWR: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(erow_phys, i_ff[IDX_W-1:0]);
            ram_wdata = m_ff;
            vbit_in[ram_waddr] = 1'b1;
            if ((j_ff + 1'b1) == n_eff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_COL;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         // Result stream
         S_ORD: begin
            ram_raddr = cell_addr(orow_phys, c_ff[IDX_W-1:0]);
            state_in  = S_OCAP;
         end
         S_OCAP: begin
            o_val_in     = rd_val;
            o_row_in     = r_ff[IDX_W-1:0];
            o_col_in     = c_ff[IDX_W-1:0];
            o_perm_in    = orow_phys;
            o_fail_in    = fail_ff;
            o_last_in    = out_last;
            rsp_valid_in = 1'b1;
            state_in     = S_OWAIT;
         end
         S_OWAIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (o_last_ff) begin
                  // Clear the run state
                  lcnt_in = '0;
                  fail_in = 1'b0;
                  vbit_in = '0;
                  for (int q = 0; q < MAX_N; q++) begin
                     perm_in[q] = IDX_W'(q);
                  end
                  state_in = S_LOAD;
               end else begin
                  if ((c_ff + 1'b1) == n_eff) begin
                     c_in = '0;
                     r_in = r_ff + 1'b1;
                  end else begin
                     c_in = c_ff + 1'b1;
                  end
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         msize_ff     <= SIZE_RESET;
         lcnt_ff      <= '0;
         fail_ff      <= 1'b0;
         vbit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < MAX_N; q++) begin
            perm_ff[q] <= IDX_W'(q);
         end
      end else begin
         state_ff     <= state_in;
         msize_ff     <= msize_in;
         lcnt_ff      <= lcnt_in;
         fail_ff      <= fail_in;
         vbit_ff      <= vbit_in;
         rsp_valid_ff <= rsp_valid_in;
         perm_ff      <= perm_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      c_ff      <= c_in;
      r_ff      <= r_in;
      prow_ff   <= prow_in;
      m_ff      <= m_in;
      x_ff      <= x_in;
      p_ff      <= p_in;
      prod_ff   <= prod_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      dsor_ff   <= dsor_in;
      neg_ff    <= neg_in;
      dcnt_ff   <= dcnt_in;
      rvld_ff   <= vbit_ff[ram_raddr];
      o_val_ff  <= o_val_in;
      o_row_ff  <= o_row_in;
      o_col_ff  <= o_col_in;
      o_perm_ff <= o_perm_in;
      o_fail_ff <= o_fail_in;
      o_last_ff <= o_last_in;
   end

   // Ports
   assign req_ch.ready         = (state_ff == S_LOAD);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.lu_value      = o_val_ff;
   assign rsp_ch.out_row       = o_row_ff;
   assign rsp_ch.out_col       = o_col_ff;
   assign rsp_ch.perm_row      = o_perm_ff;
   assign rsp_ch.factor_failed = o_fail_ff;
   assign rsp_ch.last_result   = o_last_ff;

endmodule

// ===== design/ludp_checker.sv =====
// ----------------------------------------------------------------------------
// ludp_checker: port-level checks of the pivoted LU factorization block
// Handshake ordering between loading, factorizing and result streaming.
// ----------------------------------------------------------------------------
module ludp_checker import ludp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_value,
   input logic                      rsp_last
);

   // No loading while results are pending
   a_no_load_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // The last element closes the input channel
   a_last_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("input still ready after last element");

   // The final result reopens loading
   a_last_result_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && !rsp_valid))
      else $error("block not back to loading after final result");

   // A stalled result holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind lu_decomposition_pivoted_top ludp_checker u_ludp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last_element),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.lu_value),
   .rsp_last  (rsp_ch.last_result)
);
